// File: sv/per_pixel_fragment_list_blender_core_macros.svh
// Assertion macros for the per-pixel fragment list blender checker.
// Has no dependencies; it is included by the checker file.
`ifndef PER_PIXEL_FRAGMENT_LIST_BLENDER_CORE_MACROS_SVH
`define PER_PIXEL_FRAGMENT_LIST_BLENDER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPFB_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PPFB_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// File: sv/ppfb_pkg.sv
// Shared constants, types and the blend function of the fragment list blender.
// Has no dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ppfb_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_FRAGS  = 8;

  localparam int NPIX    = MAX_WIDTH * MAX_HEIGHT;
  localparam int PIX_W   = $clog2(NPIX);
  localparam int SLOT_W  = $clog2(MAX_FRAGS);
  localparam int CNT_W   = $clog2(MAX_FRAGS + 1);
  localparam int FRAG_AW = PIX_W + SLOT_W;
  localparam int XPOS_W  = $clog2(MAX_WIDTH);
  localparam int YPOS_W  = $clog2(MAX_HEIGHT);
  localparam int DIM_W   = 7;
  localparam int IDX_PW  = YPOS_W + DIM_W + 1;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 32;

  localparam logic [1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [1:0] FUNC_ADD     = 2'd1;
  localparam logic [1:0] FUNC_COMPOSE = 2'd2;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_OFF  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [23:0] depth;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } frag_t;

  typedef struct packed {
    logic capture;
    logic loc;
    logic cnt_rd;
    logic clr_start;
    logic clr_step;
    logic add_wr;
    logic ld_start;
    logic ld_issue;
    logic blend_start;
    logic blend_step;
    logic out_load;
  } ppfb_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       on_screen;
    logic       full;
    logic       clr_last;
    logic       k_lt_n;
    logic       rd_pend;
    logic       blend_done;
    logic       out_free;
  } ppfb_stat_t;

  // One over step on one channel, rounded to nearest: (s*a + d*(255-a) + 127) / 255.
  function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                     input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] q;
    p = 16'(s) * 16'(a) + 16'(d) * 16'(8'hFF - a) + 16'd127;
    q = 17'(p) + 17'd1 + 17'(p[15:8]);
    return q[15:8];
  endfunction

endpackage

// File: sv/ppfb_ctrl.sv
// Controller state machine of the fragment list blender.
// Depends on ppfb_pkg; drives the datapath by command and reads its status.
`timescale 1ns / 1ps

module ppfb_ctrl import ppfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ppfb_stat_t st,
  output ppfb_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOC   = 3'd1;
  localparam logic [2:0] S_CNT   = 3'd2;
  localparam logic [2:0] S_CLR   = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_BLEND = 3'd5;
  localparam logic [2:0] S_RES   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       boot;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_LOC;
        end
      end
      S_LOC: begin
        cmd.loc = 1'b1;
        case (st.func)
          FUNC_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next = S_CLR;
          end
          FUNC_ADD, FUNC_COMPOSE: begin
            if (st.on_screen) begin
              cmd.cnt_rd = 1'b1;
              state_next = S_CNT;
            end else begin
              state_next = S_RES;
            end
          end
          default: state_next = S_RES;
        endcase
      end
      S_CNT: begin
        if (st.func == FUNC_ADD) begin
          cmd.add_wr = !st.full;
          state_next = S_RES;
        end else begin
          cmd.ld_start = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = boot ? S_IDLE : S_RES;
      end
      S_LOAD: begin
        cmd.ld_issue = st.k_lt_n;
        if (!st.k_lt_n && !st.rd_pend) begin
          cmd.blend_start = 1'b1;
          state_next = S_BLEND;
        end
      end
      S_BLEND: begin
        if (st.blend_done) state_next = S_RES;
        else cmd.blend_step = 1'b1;
      end
      S_RES: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      boot <= 1'b1;
    end else begin
      state <= state_next;
      if (state == S_CLR && st.clr_last) boot <= 1'b0;
    end
  end

endmodule

// File: sv/ppfb_dp.sv
// Datapath of the fragment list blender: count and fragment memories, sort list, blender.
// Depends on ppfb_pkg; commanded by ppfb_ctrl.
`timescale 1ns / 1ps

module ppfb_dp import ppfb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ppfb_cmd_t             cmd,
  output ppfb_stat_t            st,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic [1:0]            in_func,
  input  logic [DIM_W-1:0]      width_reg,
  input  logic [DIM_W-1:0]      height_reg,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [1:0]            out_user
);

  logic [1:0]   func_r;
  logic [15:0]  x_r;
  logic [15:0]  y_r;
  frag_t        frag_in_r;
  logic [23:0]  base_r;

  logic [DIM_W-1:0]  w_sat;
  logic [DIM_W-1:0]  h_sat;
  logic              on_c;
  logic              on_r;
  logic [IDX_PW-1:0] idx_sum;
  logic [PIX_W-1:0]  idx_c;
  logic [PIX_W-1:0]  idx_r;

  logic [CNT_W-1:0] cnt_mem [NPIX];
  logic [CNT_W-1:0] cnt_q;
  logic [PIX_W-1:0] clr_addr;
  logic             cnt_we;
  logic [PIX_W-1:0] cnt_wa;
  logic [CNT_W-1:0] cnt_wd;
  logic             full;
  logic [CNT_W-1:0] n_c;

  frag_t            frag_mem [1 << FRAG_AW];
  frag_t            frag_q;
  logic [CNT_W-1:0] k_r;
  logic             rd_pend;

  frag_t            list_r [MAX_FRAGS];
  frag_t            list_ins [MAX_FRAGS];
  logic [MAX_FRAGS-1:0] ge;
  logic [CNT_W-1:0] m_r;
  logic [CNT_W-1:0] i_r;
  frag_t            cur;
  logic [7:0]       red_r;
  logic [7:0]       green_r;
  logic [7:0]       blue_r;

  logic [1:0]       res_status;
  logic [23:0]      res_color;
  logic [CNT_W-1:0] res_count;
  logic [1:0]       out_status;
  logic [23:0]      out_color;
  logic [CNT_W-1:0] out_count;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r          <= in_func;
      x_r             <= in_data[15:0];
      y_r             <= in_data[31:16];
      frag_in_r.depth <= in_data[55:32];
      frag_in_r.red   <= in_data[63:56];
      frag_in_r.green <= in_data[71:64];
      frag_in_r.blue  <= in_data[79:72];
      frag_in_r.alpha <= in_data[87:80];
      base_r          <= in_data[111:88];
    end
  end

  assign w_sat = (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
  assign h_sat = (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
  assign on_c = !x_r[15] && !y_r[15] && (x_r < 16'(w_sat)) && (y_r < 16'(h_sat));
  assign idx_sum = IDX_PW'(y_r[YPOS_W-1:0]) * IDX_PW'(w_sat) + IDX_PW'(x_r[XPOS_W-1:0]);
  assign idx_c = idx_sum[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.loc) begin
      on_r  <= on_c;
      idx_r <= idx_c;
    end
  end

  assign cnt_we = cmd.clr_step | cmd.add_wr;
  assign cnt_wa = cmd.clr_step ? clr_addr : idx_r;
  assign cnt_wd = cmd.clr_step ? '0 : cnt_q + 1'b1;
  assign full = (cnt_q >= CNT_W'(MAX_FRAGS));
  assign n_c = full ? CNT_W'(MAX_FRAGS) : cnt_q;

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cmd.cnt_rd) cnt_q <= cnt_mem[idx_c];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) clr_addr <= '0;
    else if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.add_wr) frag_mem[{idx_r, cnt_q[SLOT_W-1:0]}] <= frag_in_r;
    if (cmd.ld_issue) frag_q <= frag_mem[{idx_r, k_r[SLOT_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.ld_start) begin
      rd_pend <= 1'b0;
      k_r <= '0;
    end else begin
      rd_pend <= cmd.ld_issue;
      if (cmd.ld_issue) k_r <= k_r + 1'b1;
    end
  end

  // The list stays sorted far to near; a new entry goes after all entries at
  // least as far away, which keeps equal depths in insertion order.
  always_comb begin
    for (int j = 0; j < MAX_FRAGS; j++) begin
      ge[j] = (CNT_W'(j) < m_r) && (list_r[j].depth >= frag_q.depth);
    end
    for (int j = 0; j < MAX_FRAGS; j++) begin
      if (ge[j]) list_ins[j] = list_r[j];
      else if (j == 0) list_ins[j] = frag_q;
      else if (ge[j-1]) list_ins[j] = frag_q;
      else list_ins[j] = list_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_start) begin
      m_r <= '0;
    end else if (rd_pend) begin
      list_r <= list_ins;
      m_r <= m_r + 1'b1;
    end
  end

  assign cur = list_r[i_r[SLOT_W-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.blend_start) begin
      i_r     <= '0;
      red_r   <= base_r[23:16];
      green_r <= base_r[15:8];
      blue_r  <= base_r[7:0];
    end else if (cmd.blend_step) begin
      i_r     <= i_r + 1'b1;
      red_r   <= mix(cur.red, red_r, cur.alpha);
      green_r <= mix(cur.green, green_r, cur.alpha);
      blue_r  <= mix(cur.blue, blue_r, cur.alpha);
    end
  end

  always_comb begin
    res_status = STATUS_DONE;
    res_color = '0;
    res_count = '0;
    case (func_r)
      FUNC_ADD: begin
        if (!on_r) begin
          res_status = STATUS_OFF;
        end else if (full) begin
          res_status = STATUS_FULL;
          res_count = CNT_W'(MAX_FRAGS);
        end else begin
          res_count = cnt_q + 1'b1;
        end
      end
      FUNC_COMPOSE: begin
        if (!on_r) begin
          res_status = STATUS_OFF;
          res_color = base_r;
        end else begin
          res_color = {red_r, green_r, blue_r};
          res_count = n_c;
        end
      end
      default: begin
        res_status = STATUS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_color  <= res_color;
      out_count  <= res_count;
    end
  end

  assign out_data = {(OUT_DATA_W - 24 - CNT_W)'(0), out_count, out_color};
  assign out_user = out_status;

  assign st.func       = func_r;
  assign st.on_screen  = on_c;
  assign st.full       = full;
  assign st.clr_last   = (clr_addr == PIX_W'(NPIX - 1));
  assign st.k_lt_n     = (k_r < n_c);
  assign st.rd_pend    = rd_pend;
  assign st.blend_done = (i_r == n_c);
  assign st.out_free   = !out_valid || out_ready;

endmodule

// File: sv/per_pixel_fragment_list_blender_core.sv
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: pos_x, pos_y, frag_depth, red, green, blue, alpha, base_color
//                tuser: func
// m_axis    out  tdata: blended_color, list_count; tuser: status
// APB       in   reg 0 screen_width at 0x0, reg 1 screen_height at 0x4
//
// A compose reads the fragment memory one slot a cycle for the n held fragments and
// then blends one fragment a cycle. A clear sweeps the count memory, one pixel a cycle.
// After reset the same sweep runs before the first beat is taken. A finished result
// waits in the output register while the next beat is accepted.
`timescale 1ns / 1ps

module per_pixel_fragment_list_blender_core import ppfb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pos_x[15:0], pos_y[31:16], frag_depth[55:32], frag_red[63:56], frag_green[71:64],
  // frag_blue[79:72], frag_alpha[87:80], base_color[111:88]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // blended_color[23:0], list_count[27:24], zero fill above
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]            m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  ppfb_cmd_t        cmd;
  ppfb_stat_t       st;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= DIM_W'(64);
      height_reg <= DIM_W'(64);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WIDTH) width_reg <= pwdata[DIM_W-1:0];
      else height_reg <= pwdata[DIM_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

  ppfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ppfb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_data    (s_axis_tdata),
    .in_func    (s_axis_tuser),
    .width_reg  (width_reg),
    .height_reg (height_reg),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_data   (m_axis_tdata),
    .out_user   (m_axis_tuser)
  );

endmodule

// File: sv/ppfb_checker.sv
// Port-level checker for the fragment list blender, bound to the top level.
// Depends on ppfb_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "per_pixel_fragment_list_blender_core_macros.svh"

module ppfb_checker import ppfb_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]            m_axis_tuser
);

  `PPFB_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `PPFB_ASSERT_NXT(a_busy_after_beat, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `PPFB_ASSERT_IMP(a_full_count, clk, rst, m_axis_tvalid && m_axis_tuser == STATUS_FULL, m_axis_tdata[27:24] == 4'(MAX_FRAGS))
  `PPFB_ASSERT_IMP(a_off_count, clk, rst, m_axis_tvalid && m_axis_tuser == STATUS_OFF, m_axis_tdata[27:24] == 4'd0)

endmodule

bind per_pixel_fragment_list_blender_core ppfb_checker u_ppfb_checker (.*);
